@@ hdl/scfa_pkg.sv @@
// shared types, codes and constants of the size class allocator
package scfa_pkg;

  localparam int NUM_CLASSES = 5;

  // result status codes
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_TOO_LARGE  = 3'd1;
  localparam logic [2:0] ST_EXHAUSTED  = 3'd2;
  localparam logic [2:0] ST_INVALID    = 3'd3;
  localparam logic [2:0] ST_TABLE_FULL = 3'd4;

  // action codes
  localparam logic ACT_ALLOC   = 1'b0;
  localparam logic ACT_RELEASE = 1'b1;

  // configuration register indexes
  localparam logic CFG_HEAP_BASE  = 1'b0;
  localparam logic CFG_HEAP_LIMIT = 1'b1;

  typedef struct packed {
    logic        action;
    logic [15:0] request_size;
    logic [31:0] chunk_address;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] block_address;
    logic [9:0]  granted_size;
  } out_item_t;

  // what a probe does when it reaches its cell
  typedef enum logic [1:0] {
    PM_FIND_ADDR  = 2'd0,
    PM_TAKE_INDEX = 2'd1,
    PM_WRITE      = 2'd2
  } probe_mode_t;

  typedef struct packed {
    logic        valid;
    probe_mode_t mode;
    logic        found;
    logic [2:0]  cls;
  } probe_ctl_t;

  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_QREAD = 2'd1,
    S_WAIT  = 2'd2
  } state_t;

  // bytes of each size class
  function automatic logic [9:0] class_bytes(input logic [2:0] c);
    logic [9:0] b;
    unique case (c)
      3'd0:    b = 10'd32;
      3'd1:    b = 10'd64;
      3'd2:    b = 10'd128;
      3'd3:    b = 10'd256;
      default: b = 10'd512;
    endcase
    return b;
  endfunction

endpackage

@@ hdl/scfa_ram.sv @@
// generic single write port ram with registered read
module scfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/scfa_cell.sv @@
// one record cell of the chain: holds a block record and passes the probe on
module scfa_cell #(
  parameter int ADDR_BITS = 32,
  parameter int IDX_BITS  = 6,
  parameter int IDX       = 0
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  scfa_pkg::probe_ctl_t         ctl_in,
  input  logic [((ADDR_BITS > 32) ? ADDR_BITS : 32)-1:0] addr_in,
  input  logic [IDX_BITS-1:0]          idx_in,
  output scfa_pkg::probe_ctl_t         ctl_out,
  output logic [((ADDR_BITS > 32) ? ADDR_BITS : 32)-1:0] addr_out,
  output logic [IDX_BITS-1:0]          idx_out
);

  localparam int LW = (ADDR_BITS > 32) ? ADDR_BITS : 32;

  logic                 valid_r, valid_nxt;
  logic                 use_r, use_nxt;
  logic [ADDR_BITS-1:0] own_addr_r, own_addr_nxt;
  logic [2:0]           own_cls_r, own_cls_nxt;

  scfa_pkg::probe_ctl_t  ctl_nxt;
  logic                  pvalid_r;
  scfa_pkg::probe_mode_t pmode_r;
  logic                  pfound_r;
  logic [2:0]            pcls_r;
  logic [LW-1:0]         addr_r, addr_nxt;
  logic [IDX_BITS-1:0]   idx_r, idx_nxt;

  logic match_addr;
  logic match_idx;

  // local compare and record update
  always_comb begin
    match_addr   = valid_r && use_r && (LW'(own_addr_r) == addr_in);
    match_idx    = (idx_in == IDX_BITS'(IDX));
    valid_nxt    = valid_r;
    use_nxt      = use_r;
    own_addr_nxt = own_addr_r;
    own_cls_nxt  = own_cls_r;
    ctl_nxt      = ctl_in;
    addr_nxt     = addr_in;
    idx_nxt      = idx_in;
    if (ctl_in.valid && !ctl_in.found) begin
      unique case (ctl_in.mode)
        scfa_pkg::PM_FIND_ADDR: begin
          if (match_addr) begin
            use_nxt       = 1'b0;
            ctl_nxt.found = 1'b1;
            ctl_nxt.cls   = own_cls_r;
            idx_nxt       = IDX_BITS'(IDX);
          end
        end
        scfa_pkg::PM_TAKE_INDEX: begin
          if (match_idx) begin
            use_nxt       = 1'b1;
            ctl_nxt.found = 1'b1;
            addr_nxt      = LW'(own_addr_r);
          end
        end
        scfa_pkg::PM_WRITE: begin
          if (match_idx) begin
            valid_nxt     = 1'b1;
            use_nxt       = 1'b1;
            own_addr_nxt  = ADDR_BITS'(addr_in);
            own_cls_nxt   = ctl_in.cls;
            ctl_nxt.found = 1'b1;
          end
        end
        default: begin
          ctl_nxt.found = 1'b0;
        end
      endcase
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= 1'b0;
      use_r    <= 1'b0;
      pvalid_r <= 1'b0;
    end else begin
      valid_r  <= valid_nxt;
      use_r    <= use_nxt;
      pvalid_r <= ctl_nxt.valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    own_addr_r <= own_addr_nxt;
    own_cls_r  <= own_cls_nxt;
    pmode_r    <= ctl_nxt.mode;
    pfound_r   <= ctl_nxt.found;
    pcls_r     <= ctl_nxt.cls;
    addr_r     <= addr_nxt;
    idx_r      <= idx_nxt;
  end

  assign ctl_out  = '{valid: pvalid_r, mode: pmode_r, found: pfound_r, cls: pcls_r};
  assign addr_out = addr_r;
  assign idx_out  = idx_r;

endmodule

@@ hdl/size_class_first_fit_allocator_core.sv @@
// size class first fit allocator: controller, free queues and record chain
// Usage: a request transfer happens when start is high and busy is low.
// in_data.action selects allocate or release. Each request gives exactly one
// result, shown on out_data for one cycle with out_valid high; the receiver
// cannot stall, so it must take the result in that cycle.
// An allocate above 512 bytes, or one that fails on heap space or a full
// record table, is answered from the idle state with no probe. Every other
// request sends a probe through the chain of MAX_RECORDS record cells, one
// cell per cycle, and is answered once the probe leaves the last cell (a
// reuse from a free queue first reads the queue memory in S_QREAD). One
// request is in work at a time: the next may start in the cycle the result
// is shown.
// Configuration: cfg_we at index 0 (heap_base) loads the break while no block
// has been carved yet; index 1 writes heap_limit. The user must write only
// while the block is idle; the block does not enforce it. Reset clears all
// records, queues and the break, sets the limit to all ones, no clearing pass.
module size_class_first_fit_allocator_core #(
  parameter int MAX_RECORDS = 64,
  parameter int ADDR_BITS   = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  scfa_pkg::in_item_t  in_data,
  output logic                out_valid,
  output scfa_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [31:0]         cfg_wdata
);

  localparam int LW  = (ADDR_BITS > 32) ? ADDR_BITS : 32;
  localparam int IW  = $clog2(MAX_RECORDS);
  localparam int CW  = $clog2(MAX_RECORDS + 1);
  localparam int QD  = scfa_pkg::NUM_CLASSES * MAX_RECORDS;
  localparam int QAW = $clog2(QD);

  scfa_pkg::state_t state_r, state_nxt;

  logic [ADDR_BITS-1:0] break_r, break_nxt;
  logic [31:0]          limit_r, limit_nxt;
  logic [CW-1:0]        count_r, count_nxt;
  logic [IW-1:0]        head_r [scfa_pkg::NUM_CLASSES];
  logic [IW-1:0]        head_nxt [scfa_pkg::NUM_CLASSES];
  logic [IW-1:0]        tail_r [scfa_pkg::NUM_CLASSES];
  logic [IW-1:0]        tail_nxt [scfa_pkg::NUM_CLASSES];
  logic [CW-1:0]        fill_r [scfa_pkg::NUM_CLASSES];
  logic [CW-1:0]        fill_nxt [scfa_pkg::NUM_CLASSES];
  logic [2:0]           cls_r, cls_nxt;

  logic                 out_valid_r, out_valid_nxt;
  scfa_pkg::out_item_t  out_data_r, out_data_nxt;

  // chain wiring
  scfa_pkg::probe_ctl_t ctl_w  [MAX_RECORDS+1];
  logic [LW-1:0]        addr_w [MAX_RECORDS+1];
  logic [IW-1:0]        idx_w  [MAX_RECORDS+1];
  logic [MAX_RECORDS-1:0] probe_v;

  // probe launched into the first cell
  scfa_pkg::probe_ctl_t ctl0;
  logic [LW-1:0]        addr0;
  logic [IW-1:0]        idx0;

  // free queue memory
  logic           q_we;
  logic [QAW-1:0] q_waddr, q_raddr;
  logic [IW-1:0]  q_wdata, q_rdata;

  logic [2:0]         in_cls;
  logic               too_large;
  logic [ADDR_BITS:0] sum;
  logic               exhausted;
  logic [2:0]         c_end;

  // size class of the incoming request
  always_comb begin
    too_large = 1'b0;
    in_cls    = 3'd0;
    priority if (in_data.request_size <= 16'd32) begin
      in_cls = 3'd0;
    end else if (in_data.request_size <= 16'd64) begin
      in_cls = 3'd1;
    end else if (in_data.request_size <= 16'd128) begin
      in_cls = 3'd2;
    end else if (in_data.request_size <= 16'd256) begin
      in_cls = 3'd3;
    end else if (in_data.request_size <= 16'd512) begin
      in_cls = 3'd4;
    end else begin
      too_large = 1'b1;
    end
  end

  // break growth check
  always_comb begin
    sum       = {1'b0, break_r} + (ADDR_BITS+1)'(scfa_pkg::class_bytes(in_cls));
    exhausted = sum[ADDR_BITS] || (LW'(sum[ADDR_BITS-1:0]) > LW'(limit_r));
  end

  assign c_end = ctl_w[MAX_RECORDS].cls;

  // controller next state and outputs
  always_comb begin
    state_nxt     = state_r;
    break_nxt     = break_r;
    limit_nxt     = limit_r;
    count_nxt     = count_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    fill_nxt      = fill_r;
    cls_nxt       = cls_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    q_we          = 1'b0;
    q_waddr       = QAW'(c_end) * QAW'(MAX_RECORDS) + QAW'(tail_r[c_end]);
    q_wdata       = idx_w[MAX_RECORDS];
    q_raddr       = QAW'(in_cls) * QAW'(MAX_RECORDS) + QAW'(head_r[in_cls]);
    ctl0          = '{valid: 1'b0, mode: scfa_pkg::PM_FIND_ADDR, found: 1'b0,
                      cls: in_cls};
    addr0         = LW'(in_data.chunk_address);
    idx0          = IW'(count_r);

    // configuration writes
    if (cfg_we) begin
      unique case (cfg_index)
        scfa_pkg::CFG_HEAP_BASE: begin
          if (count_r == '0) begin
            break_nxt = ADDR_BITS'(cfg_wdata);
          end
        end
        default: limit_nxt = cfg_wdata;
      endcase
    end

    unique case (state_r)
      scfa_pkg::S_IDLE: begin
        if (start) begin
          cls_nxt = in_cls;
          if (in_data.action == scfa_pkg::ACT_RELEASE) begin
            ctl0.valid = 1'b1;
            state_nxt  = scfa_pkg::S_WAIT;
          end else if (too_large) begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = '{status: scfa_pkg::ST_TOO_LARGE, block_address: '0,
                              granted_size: '0};
          end else if (fill_r[in_cls] != '0) begin
            state_nxt = scfa_pkg::S_QREAD;
          end else if (exhausted) begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = '{status: scfa_pkg::ST_EXHAUSTED, block_address: '0,
                              granted_size: '0};
          end else if (count_r >= CW'(MAX_RECORDS)) begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = '{status: scfa_pkg::ST_TABLE_FULL, block_address: '0,
                              granted_size: '0};
          end else begin
            ctl0.valid = 1'b1;
            ctl0.mode  = scfa_pkg::PM_WRITE;
            addr0      = LW'(break_r);
            break_nxt  = sum[ADDR_BITS-1:0];
            count_nxt  = count_r + CW'(1);
            state_nxt  = scfa_pkg::S_WAIT;
          end
        end
      end
      scfa_pkg::S_QREAD: begin
        // queue head entry is on the memory output now
        ctl0.valid = 1'b1;
        ctl0.mode  = scfa_pkg::PM_TAKE_INDEX;
        ctl0.cls   = cls_r;
        idx0       = q_rdata;
        head_nxt[cls_r] = (head_r[cls_r] == IW'(MAX_RECORDS - 1)) ? '0
                                                                  : head_r[cls_r] + IW'(1);
        fill_nxt[cls_r] = fill_r[cls_r] - CW'(1);
        state_nxt       = scfa_pkg::S_WAIT;
      end
      scfa_pkg::S_WAIT: begin
        if (ctl_w[MAX_RECORDS].valid) begin
          out_valid_nxt = 1'b1;
          state_nxt     = scfa_pkg::S_IDLE;
          unique case (ctl_w[MAX_RECORDS].mode)
            scfa_pkg::PM_FIND_ADDR: begin
              if (ctl_w[MAX_RECORDS].found) begin
                if (fill_r[c_end] < CW'(MAX_RECORDS)) begin
                  q_we           = 1'b1;
                  tail_nxt[c_end] = (tail_r[c_end] == IW'(MAX_RECORDS - 1)) ? '0
                                    : tail_r[c_end] + IW'(1);
                  fill_nxt[c_end] = fill_r[c_end] + CW'(1);
                end
                out_data_nxt = '{status: scfa_pkg::ST_OK, block_address: '0,
                                 granted_size: '0};
              end else begin
                out_data_nxt = '{status: scfa_pkg::ST_INVALID, block_address: '0,
                                 granted_size: '0};
              end
            end
            default: begin
              out_data_nxt = '{status: scfa_pkg::ST_OK,
                               block_address: 32'(addr_w[MAX_RECORDS]),
                               granted_size: scfa_pkg::class_bytes(cls_r)};
            end
          endcase
        end
      end
      default: state_nxt = scfa_pkg::S_IDLE;
    endcase
  end

  // controller registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= scfa_pkg::S_IDLE;
      break_r     <= '0;
      limit_r     <= '1;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      for (int k = 0; k < scfa_pkg::NUM_CLASSES; k++) begin
        head_r[k] <= '0;
        tail_r[k] <= '0;
        fill_r[k] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      break_r     <= break_nxt;
      limit_r     <= limit_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      fill_r      <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cls_r      <= cls_nxt;
    out_data_r <= out_data_nxt;
  end

  assign busy      = (state_r != scfa_pkg::S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // chain entry
  assign ctl_w[0]  = ctl0;
  assign addr_w[0] = addr0;
  assign idx_w[0]  = idx0;

  // free queue slots of all classes
  scfa_ram #(
    .WIDTH (IW),
    .DEPTH (QD)
  ) u_queue_ram (
    .clk   (clk),
    .we    (q_we),
    .waddr (q_waddr),
    .wdata (q_wdata),
    .raddr (q_raddr),
    .rdata (q_rdata)
  );

  // record cell chain
  for (genvar i = 0; i < MAX_RECORDS; i++) begin : g_cell
    scfa_cell #(
      .ADDR_BITS (ADDR_BITS),
      .IDX_BITS  (IW),
      .IDX       (i)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl_in   (ctl_w[i]),
      .addr_in  (addr_w[i]),
      .idx_in   (idx_w[i]),
      .ctl_out  (ctl_w[i+1]),
      .addr_out (addr_w[i+1]),
      .idx_out  (idx_w[i+1])
    );
    assign probe_v[i] = ctl_w[i+1].valid;
  end

`ifndef SYNTHESIS
  // at most one probe travels the chain
  a_one_probe: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(probe_v))
    else $error("more than one probe in the record chain");

  // a probe leaves the chain only while the controller waits for it
  a_probe_wait: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_w[MAX_RECORDS].valid |-> state_r == scfa_pkg::S_WAIT)
    else $error("probe left the chain outside the wait state");

  // results are shown only after the controller returns to idle
  a_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> state_r == scfa_pkg::S_IDLE)
    else $error("result shown while busy");

  // the record count never passes the table size
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_RECORDS))
    else $error("record count beyond table size");
`endif

endmodule
